// File: rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Field widths, operation and status codes, the stored entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // Default number of slots in the entry store.
    localparam int DEPTH_DEF = 16;

    // Field widths of the channels.
    localparam int FUNC_W = 2;
    localparam int ID_W   = 16;
    localparam int PRI_W  = 3;
    localparam int PAY_W  = 16;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 5;
    localparam int LIM_W  = 5;

    // Occupancy limit after reset, and the highest recognized priority.
    localparam logic [LIM_W-1:0] LIMIT_RESET  = 5'd10;
    localparam logic [PRI_W-1:0] MAX_PRIORITY = 3'd4;

    // Operation codes of an input beat.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 2'd0,
        FN_DEQUEUE = 2'd1,
        FN_CANCEL  = 2'd2
    } t_func;

    // Status codes of a result beat.
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_EVICTED   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CANCELLED = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } t_entry;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAIL_EV,
        S_INS_RD,
        S_INS_EV,
        S_SRCH_RD,
        S_SRCH_EV,
        S_SHIFT_RD,
        S_SHIFT_EV,
        S_DONE
    } t_state;

    // Slot pointer updates.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_HELD,
        IDX_HELD_M1,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    // Entry count updates.
    typedef enum logic [1:0] {
        HELD_HOLD,
        HELD_INC,
        HELD_DEC
    } t_held_op;

    // Read address sources.
    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1,
        RD_HELD_M1
    } t_rd_sel;

    // Write data sources.
    typedef enum logic {
        WR_ITEM,
        WR_RAM
    } t_wr_src;

    // Sources of the reported entry.
    typedef enum logic [1:0] {
        REP_ZERO,
        REP_ITEM,
        REP_RAM
    } t_rep_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     in_ready;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_src  wr_src;
        t_idx_op  idx_op;
        t_held_op held_op;
        logic     res_we;
        t_status  res_status;
        t_rep_src rep_src;
        logic     out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              in_valid;
        logic [FUNC_W-1:0] func;
        logic              held_lt_limit;
        logic              held_zero;
        logic              idx_zero;
        logic              idx_lt_held;
        logic              idx_p1_lt_held;
        logic              evict;
        logic              ins_stop;
        logic              match;
        logic              out_free;
    } t_sts;

endpackage

// File: rtl/bpq_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue operation per beat.
// ----------------------------------------------------------------------------
interface bpq_req_if;
    import bpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   entry_id;
    logic [PRI_W-1:0]  entry_priority;
    logic [PAY_W-1:0]  entry_payload;

    modport source (
        output valid, func, entry_id, entry_priority, entry_payload,
        input  ready
    );

    modport sink (
        input  valid, func, entry_id, entry_priority, entry_payload,
        output ready
    );

endinterface

// File: rtl/bpq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one operation result per beat.
// ----------------------------------------------------------------------------
interface bpq_rsp_if;
    import bpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] op_status;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic [PAY_W-1:0]  out_payload;
    logic [OCC_W-1:0]  occupancy;

    modport source (
        output valid, op_status, out_id, out_priority, out_payload, occupancy,
        input  ready
    );

    modport sink (
        input  valid, op_status, out_id, out_priority, out_payload, occupancy,
        output ready
    );

endinterface

// File: rtl/bpq_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the occupancy limit register.
// ----------------------------------------------------------------------------
interface bpq_cfg_if;
    import bpq_pkg::*;

    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] occupancy_limit;

    modport source (
        output valid, occupancy_limit,
        input  ready
    );

    modport sink (
        input  valid, occupancy_limit,
        output ready
    );

endinterface

// File: rtl/bounded_priority_queue_evict.sv
// ----------------------------------------------------------------------------
// Bounded priority queue with tail eviction
// Sorted queue of (id, priority, payload) entries, descending priority and
// arrival order among equals, with a configurable occupancy limit.
// ----------------------------------------------------------------------------
// Usage: i_req carries one operation per beat (insert, dequeue head, cancel
// by id); o_rsp returns exactly one result beat for each request, with the
// status, the reported entry and the occupancy after the operation. i_cfg
// writes the occupancy limit and is always ready; write it only while no
// request is in flight.
// Sequencing: entries live in a RAM with a single read port and registered
// read data, so moving or inspecting one entry takes a read step and then
// an evaluate-and-write step. An insert, which may first evict the tail,
// moves each entry that it passes one slot toward the tail; a dequeue or
// a cancel searches and then closes the gap. Requests are handled one at a
// time; i_req.ready is high only while the sequencer is idle.
// Reset: the queue empties and the limit returns to 10; no clearing pass.
// Stall: a finished result waits in the output register while the next
// request is accepted; that request completes only once the register frees.
// ----------------------------------------------------------------------------
module bounded_priority_queue_evict #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpq_req_if.sink   i_req,
    bpq_rsp_if.source o_rsp,
    bpq_cfg_if.sink   i_cfg
);
    import bpq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Operation sequencer.
    bpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Storage and result datapath.
    bpq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );

`ifndef SYNTHESIS
    // In the cycle after a request beat, the request channel is not ready.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while an operation is in progress");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("pending result overwritten");

    // The response valid rises only after the sequencer has loaded a result.
    a_valid_from_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.out_load))
        else $error("response valid without a loaded result");

    // The entry store is never read and written in the same cycle.
    a_store_port : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd_en && w_cmd.wr_en))
        else $error("entry store read and written together");
`endif

endmodule

// File: rtl/bpq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded priority queue controller
// Sequences each operation over the entry store: tail check, scan and shift
// for inserts, search and close-up for dequeues and cancels.
// ----------------------------------------------------------------------------
module bpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpq_pkg::t_sts i_sts,
    output bpq_pkg::t_cmd o_cmd
);
    import bpq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.func)
                    FN_INSERT: begin
                        if (i_sts.held_lt_limit) begin
                            n_state = S_INS_RD;
                        end else if (i_sts.held_zero) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_TAIL_EV;
                        end
                    end
                    FN_DEQUEUE: begin
                        n_state = i_sts.held_zero ? S_DONE : S_SRCH_RD;
                    end
                    FN_CANCEL: begin
                        n_state = S_SRCH_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TAIL_EV: begin
                n_state = i_sts.evict ? S_INS_RD : S_DONE;
            end
            S_INS_RD: begin
                n_state = i_sts.idx_zero ? S_DONE : S_INS_EV;
            end
            S_INS_EV: begin
                n_state = i_sts.ins_stop ? S_DONE : S_INS_RD;
            end
            S_SRCH_RD: begin
                n_state = i_sts.idx_lt_held ? S_SRCH_EV : S_DONE;
            end
            S_SRCH_EV: begin
                n_state = i_sts.match ? S_SHIFT_RD : S_SRCH_RD;
            end
            S_SHIFT_RD: begin
                n_state = i_sts.idx_p1_lt_held ? S_SHIFT_EV : S_DONE;
            end
            S_SHIFT_EV: begin
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.in_ready   = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_src     = WR_ITEM;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.held_op    = HELD_HOLD;
        o_cmd.res_we     = 1'b0;
        o_cmd.res_status = ST_NOT_FOUND;
        o_cmd.rep_src    = REP_ZERO;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_DECODE: begin
                o_cmd.res_we = 1'b1;
                case (i_sts.func)
                    FN_INSERT: begin
                        if (i_sts.held_lt_limit) begin
                            o_cmd.res_status = ST_INSERTED;
                            o_cmd.idx_op     = IDX_HELD;
                        end else if (i_sts.held_zero) begin
                            o_cmd.res_status = ST_OVERFLOW;
                            o_cmd.rep_src    = REP_ITEM;
                        end else begin
                            // Fetch the tail to see whether it can be evicted.
                            o_cmd.res_we = 1'b0;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_HELD_M1;
                        end
                    end
                    FN_DEQUEUE: begin
                        o_cmd.res_status = i_sts.held_zero ? ST_EMPTY : ST_NOT_FOUND;
                        o_cmd.idx_op     = IDX_ZERO;
                    end
                    FN_CANCEL: begin
                        o_cmd.idx_op = IDX_ZERO;
                    end
                    default: begin
                        o_cmd.res_status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_TAIL_EV: begin
                o_cmd.res_we = 1'b1;
                if (i_sts.evict) begin
                    o_cmd.res_status = ST_EVICTED;
                    o_cmd.rep_src    = REP_RAM;
                    o_cmd.held_op    = HELD_DEC;
                    o_cmd.idx_op     = IDX_HELD_M1;
                end else begin
                    o_cmd.res_status = ST_OVERFLOW;
                    o_cmd.rep_src    = REP_ITEM;
                end
            end
            S_INS_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_src  = WR_ITEM;
                    o_cmd.held_op = HELD_INC;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                end
            end
            S_INS_EV: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.ins_stop) begin
                    o_cmd.wr_src  = WR_ITEM;
                    o_cmd.held_op = HELD_INC;
                end else begin
                    // Move the lower-priority entry one slot toward the tail.
                    o_cmd.wr_src = WR_RAM;
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.idx_lt_held) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                end
            end
            S_SRCH_EV: begin
                if (i_sts.match) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = (i_sts.func == FN_DEQUEUE) ? ST_DEQUEUED
                                                                  : ST_CANCELLED;
                    o_cmd.rep_src    = REP_RAM;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.idx_p1_lt_held) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_P1;
                end else begin
                    // The gap is closed; the removed entry leaves the count.
                    o_cmd.held_op = HELD_DEC;
                end
            end
            S_SHIFT_EV: begin
                // Close the gap: the next entry moves one slot toward the head.
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_RAM;
                o_cmd.idx_op = IDX_INC;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bpq_dpath.sv
// ----------------------------------------------------------------------------
// Bounded priority queue datapath
// Entry store, entry count, slot pointer, limit register, captured request,
// result register and the response output register.
// ----------------------------------------------------------------------------
module bpq_dpath #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpq_pkg::t_cmd i_cmd,
    output bpq_pkg::t_sts o_sts,
    bpq_req_if.sink       i_req,
    bpq_rsp_if.source     o_rsp,
    bpq_cfg_if.sink       i_cfg
);
    import bpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIM_W) ? CW : LIM_W;

    logic [CW-1:0]     r_held;
    logic [CW-1:0]     n_held;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     n_idx;
    logic [LIM_W-1:0]  r_limit;
    logic [FUNC_W-1:0] r_func;
    t_entry            r_item;
    t_status           r_res_status;
    t_entry            r_res_entry;
    t_entry            n_res_entry;
    logic              r_ov;
    t_status           r_out_status;
    t_entry            r_out_entry;
    logic [OCC_W-1:0]  r_out_occ;

    logic [CW-1:0]     w_rd_cnt;
    logic [CW:0]       w_idx_p1;
    logic [LW-1:0]     w_eff_limit;
    t_entry            w_rd;
    t_entry            w_wdata;
    logic              w_accept;
    logic [PRI_W-1:0]  w_in_pri;

    // Configuration register; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.occupancy_limit;
        end
    end

    // Request capture; unrecognized priorities are stored as the lowest.
    assign i_req.ready = i_cmd.in_ready;
    assign w_accept    = i_req.valid && i_cmd.in_ready;
    assign w_in_pri    = (i_req.entry_priority > MAX_PRIORITY) ? '0 : i_req.entry_priority;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= i_req.func;
            r_item.id  <= i_req.entry_id;
            r_item.pri <= w_in_pri;
            r_item.pay <= i_req.entry_payload;
        end
    end

    // Entry count.
    always_comb begin
        case (i_cmd.held_op)
            HELD_INC: n_held = r_held + CW'(1);
            HELD_DEC: n_held = r_held - CW'(1);
            default:  n_held = r_held;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    // Slot pointer.
    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:    n_idx = '0;
            IDX_HELD:    n_idx = r_held;
            IDX_HELD_M1: n_idx = r_held - CW'(1);
            IDX_INC:     n_idx = r_idx + CW'(1);
            IDX_DEC:     n_idx = r_idx - CW'(1);
            default:     n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Entry store.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1:  w_rd_cnt = r_idx - CW'(1);
            RD_IDX_P1:  w_rd_cnt = r_idx + CW'(1);
            RD_HELD_M1: w_rd_cnt = r_held - CW'(1);
            default:    w_rd_cnt = r_idx;
        endcase
    end

    assign w_wdata = (i_cmd.wr_src == WR_RAM) ? w_rd : r_item;

    bpq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_rd_cnt[AW-1:0]),
        .o_rdata (w_rd)
    );

    // Result register.
    always_comb begin
        case (i_cmd.rep_src)
            REP_ITEM: n_res_entry = r_item;
            REP_RAM:  n_res_entry = w_rd;
            default:  n_res_entry = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
            r_res_entry  <= n_res_entry;
        end
    end

    // Response output register; it frees when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_entry  <= r_res_entry;
            r_out_occ    <= OCC_W'(r_held);
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.op_status    = r_out_status;
    assign o_rsp.out_id       = r_out_entry.id;
    assign o_rsp.out_priority = r_out_entry.pri;
    assign o_rsp.out_payload  = r_out_entry.pay;
    assign o_rsp.occupancy    = r_out_occ;

    // Status to the controller.
    assign w_eff_limit = (LW'(r_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_limit);
    assign w_idx_p1    = {1'b0, r_idx} + (CW + 1)'(1);

    assign o_sts.in_valid       = i_req.valid;
    assign o_sts.func           = r_func;
    assign o_sts.held_lt_limit  = LW'(r_held) < w_eff_limit;
    assign o_sts.held_zero      = (r_held == '0);
    assign o_sts.idx_zero       = (r_idx == '0);
    assign o_sts.idx_lt_held    = r_idx < r_held;
    assign o_sts.idx_p1_lt_held = w_idx_p1 < {1'b0, r_held};
    assign o_sts.evict          = r_item.pri > w_rd.pri;
    assign o_sts.ins_stop       = w_rd.pri >= r_item.pri;
    assign o_sts.match          = (r_func == FN_DEQUEUE) || (w_rd.id == r_item.id);
    assign o_sts.out_free       = !r_ov || o_rsp.ready;

endmodule
